FILE: design/rbf_pkg.sv
// rbf_pkg: shared types and constants of the rgb 3x3 box filter
`default_nettype none
package rbf_pkg;

    localparam int CHAN_W    = 8;
    localparam int NCHAN     = 3;
    localparam int CH_RED    = 2;
    localparam int CH_GREEN  = 1;
    localparam int CH_BLUE   = 0;
    localparam int COORD_W   = 12;
    localparam int TAPS      = 9;

    localparam int DEF_MAX_WIDTH = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_SIDE      = 3;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // divide by nine as multiply by ceil(2^16 / 9) and shift
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = 7282;
    localparam int PROD_W      = 25;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    typedef logic [NCHAN-1:0][CHAN_W-1:0] pix_t;

    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_t;

    typedef struct packed {
        logic               r_first;
        logic               r_ge2;
        logic               r_last;
        logic               c_ge1;
        logic               c_ge2;
        logic               c_last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pix_t               pix;
    } meta_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        pix_t               pix;
        logic               frame_done;
    } res_t;

endpackage
`default_nettype wire

FILE: design/rbf_line_store.sv
// rbf_line_store: two-row line store memory with registered read
`default_nettype none
module rbf_line_store #(
    parameter int DEPTH = rbf_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire               aclk,
    input  wire               rd_en,
    input  wire [AW-1:0]      rd_addr,
    output rbf_pkg::line_t    rd_data,
    input  wire               wr_en,
    input  wire [AW-1:0]      wr_addr,
    input  rbf_pkg::line_t    wr_data
);

    rbf_pkg::line_t mem [DEPTH];
    rbf_pkg::line_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: design/rbf_lane.sv
// rbf_lane: one colour channel, nine-tap sum and divide by nine
`default_nettype none
module rbf_lane (
    input  wire                                            aclk,
    input  wire                                            en,
    input  wire [rbf_pkg::TAPS-1:0][rbf_pkg::CHAN_W-1:0]   taps,
    output logic [rbf_pkg::CHAN_W-1:0]                     mean
);

    localparam logic [rbf_pkg::PROD_W-1:0] RECIP_K = rbf_pkg::PROD_W'(rbf_pkg::RECIP);

    logic [rbf_pkg::SUM_W-1:0]  sum_next;
    logic [rbf_pkg::SUM_W-1:0]  sum_reg;
    logic [rbf_pkg::PROD_W-1:0] prod_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < rbf_pkg::TAPS; i++) begin
            sum_next = sum_next + rbf_pkg::SUM_W'(taps[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next;
            prod_reg <= rbf_pkg::PROD_W'(sum_reg) * RECIP_K;
        end
    end

    assign mean = prod_reg[rbf_pkg::RECIP_SHIFT +: rbf_pkg::CHAN_W];

endmodule
`default_nettype wire

FILE: design/rbf_merge_out.sv
// rbf_merge_out: merges lane results into up to three output pixels and sends them
`default_nettype none
module rbf_merge_out (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  load_valid,
    input  rbf_pkg::meta_t                       meta,
    input  rbf_pkg::pix_t                        mean,
    input  rbf_pkg::pix_t                        mid_pix,
    input  rbf_pkg::pix_t                        right_pix,
    output logic                                 take_ok,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // row[11:0], col[23:12], red[31:24], green[39:32], blue[47:40]
    output logic [rbf_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    // frame_done[0]
    output logic                                 m_tuser
);

    rbf_pkg::res_t cand [4];
    logic [3:0]    cand_en;
    rbf_pkg::res_t bundle [4];
    logic [2:0]    n_next;

    rbf_pkg::res_t res_reg [3];
    logic [1:0]    cnt_reg;

    always_comb begin
        cand[0].row        = meta.row;
        cand[0].col        = meta.col;
        cand[0].pix        = meta.pix;
        cand[0].frame_done = 1'b0;
        cand_en[0]         = meta.r_first;

        cand[1].row        = meta.row - rbf_pkg::COORD_W'(1);
        cand[1].col        = meta.col - rbf_pkg::COORD_W'(1);
        cand[1].pix        = meta.c_ge2 ? mean : mid_pix;
        cand[1].frame_done = 1'b0;
        cand_en[1]         = meta.r_ge2 && meta.c_ge1;

        cand[2].row        = meta.row - rbf_pkg::COORD_W'(1);
        cand[2].col        = meta.col;
        cand[2].pix        = right_pix;
        cand[2].frame_done = 1'b0;
        cand_en[2]         = meta.r_ge2 && meta.c_last;

        cand[3].row        = meta.row;
        cand[3].col        = meta.col;
        cand[3].pix        = meta.pix;
        cand[3].frame_done = meta.c_last;
        cand_en[3]         = meta.r_last;
    end

    // pack the enabled candidates in order
    always_comb begin
        n_next = '0;
        for (int i = 0; i < 4; i++) begin
            bundle[i] = cand[0];
        end
        for (int i = 0; i < 4; i++) begin
            if (cand_en[i]) begin
                bundle[n_next[1:0]] = cand[i];
                n_next = n_next + 3'd1;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign take_ok  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (take_ok && load_valid) begin
            cnt_reg <= n_next[1:0];
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_ok && load_valid) begin
            res_reg[0] <= bundle[0];
            res_reg[1] <= bundle[1];
            res_reg[2] <= bundle[2];
        end else if (m_tvalid && m_tready) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign m_tdata = {res_reg[0].pix[rbf_pkg::CH_BLUE], res_reg[0].pix[rbf_pkg::CH_GREEN],
                      res_reg[0].pix[rbf_pkg::CH_RED], res_reg[0].col, res_reg[0].row};
    assign m_tlast = (cnt_reg == 2'd1);
    assign m_tuser = res_reg[0].frame_done;

endmodule
`default_nettype wire

FILE: design/rgb_box_filter_3x3.sv
// rgb_box_filter_3x3: top level of the streaming rgb 3x3 mean filter
// Takes one rgb pixel per clock in raster order and returns each pixel with its row and
// column, the interior ones replaced by the truncated mean of their 3x3 neighbourhood and
// the border ones unchanged. A pixel is taken every cycle while the output side keeps up;
// results leave one per clock while m_tready is high, so a pixel with several results holds
// the input until its last result is being sent: each pixel of the last row after its first
// column and the last pixel of each row from the third row on give two results, and the last
// pixel of the frame gives three. Rows are held in one line store memory read when a pixel is
// taken and written as the pixel leaves the first pipeline register; the three channels are
// summed and divided by nine in parallel lanes.
// Writing either register restarts the frame at row 0, column 0; widths are limited to
// 3..MAX_WIDTH and heights to 3..4096.
`default_nettype none
module rgb_box_filter_3x3 #(
    parameter int MAX_WIDTH = rbf_pkg::DEF_MAX_WIDTH
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_we,
    input  wire [rbf_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire [rbf_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  wire [rbf_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // out_row[11:0], out_col[23:12], red_out[31:24], green_out[39:32], blue_out[47:40]
    output logic [rbf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // frame_done[0]
    output logic                               m_tuser
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int W_RESET = (rbf_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                : rbf_pkg::RESET_WIDTH;
    localparam logic [CW-1:0] W_RESET_LAST = CW'(W_RESET - 1);
    localparam logic [rbf_pkg::COORD_W-1:0] H_RESET_LAST =
        rbf_pkg::COORD_W'(rbf_pkg::RESET_HEIGHT - 1);

    logic [CW-1:0]               w_last_reg;
    logic [rbf_pkg::COORD_W-1:0] h_last_reg;
    logic [CW-1:0]               col_reg, col_next;
    logic [rbf_pkg::COORD_W-1:0] row_reg, row_next;

    logic           adv;
    logic           accept;
    rbf_pkg::meta_t meta_in;
    rbf_pkg::meta_t m1_reg, m2_reg, m3_reg, m4_reg;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0]  addr1_reg;
    rbf_pkg::line_t rd_data;
    rbf_pkg::line_t wr_data;
    rbf_pkg::pix_t  win_reg [3][3];
    rbf_pkg::pix_t  mid3_reg, right3_reg, mid4_reg, right4_reg;
    rbf_pkg::pix_t  mean;

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // configuration, limited to the supported frame sizes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= W_RESET_LAST;
            h_last_reg <= H_RESET_LAST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rbf_pkg::REG_IMAGE_WIDTH: begin
                    if (32'(cfg_wdata) < 32'(rbf_pkg::MIN_SIDE)) begin
                        w_last_reg <= CW'(rbf_pkg::MIN_SIDE - 1);
                    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
                        w_last_reg <= CW'(MAX_WIDTH - 1);
                    end else begin
                        w_last_reg <= CW'(cfg_wdata - rbf_pkg::CFG_W'(1));
                    end
                end
                rbf_pkg::REG_IMAGE_HEIGHT: begin
                    if (32'(cfg_wdata) < 32'(rbf_pkg::MIN_SIDE)) begin
                        h_last_reg <= rbf_pkg::COORD_W'(rbf_pkg::MIN_SIDE - 1);
                    end else if (32'(cfg_wdata) > 32'(rbf_pkg::MAX_HEIGHT)) begin
                        h_last_reg <= rbf_pkg::COORD_W'(rbf_pkg::MAX_HEIGHT - 1);
                    end else begin
                        h_last_reg <= rbf_pkg::COORD_W'(cfg_wdata - rbf_pkg::CFG_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg == w_last_reg) begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + rbf_pkg::COORD_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_we && (cfg_addr == rbf_pkg::REG_IMAGE_WIDTH ||
                                cfg_addr == rbf_pkg::REG_IMAGE_HEIGHT)) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb begin
        meta_in.r_first = (row_reg == '0);
        meta_in.r_ge2   = (row_reg >= rbf_pkg::COORD_W'(2));
        meta_in.r_last  = (row_reg == h_last_reg);
        meta_in.c_ge1   = (col_reg != '0);
        meta_in.c_ge2   = (32'(col_reg) >= 32'd2);
        meta_in.c_last  = (col_reg == w_last_reg);
        meta_in.row     = row_reg;
        meta_in.col     = rbf_pkg::COORD_W'(col_reg);
        meta_in.pix[rbf_pkg::CH_RED]   = s_tdata[7:0];
        meta_in.pix[rbf_pkg::CH_GREEN] = s_tdata[15:8];
        meta_in.pix[rbf_pkg::CH_BLUE]  = s_tdata[23:16];
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg     <= meta_in;
            addr1_reg  <= col_reg;
            m2_reg     <= m1_reg;
            m3_reg     <= m2_reg;
            m4_reg     <= m3_reg;
            mid3_reg   <= win_reg[1][1];
            right3_reg <= win_reg[1][2];
            mid4_reg   <= mid3_reg;
            right4_reg <= right3_reg;
        end
    end

    assign wr_data.upper = rd_data.lower;
    assign wr_data.lower = m1_reg.pix;

    rbf_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (adv && v1_reg),
        .wr_addr (addr1_reg),
        .wr_data (wr_data)
    );

    // window shifts left as each pixel enters
    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_data.upper;
            win_reg[1][2] <= rd_data.lower;
            win_reg[2][2] <= m1_reg.pix;
        end
    end

    for (genvar ch = 0; ch < rbf_pkg::NCHAN; ch++) begin : g_lane
        logic [rbf_pkg::TAPS-1:0][rbf_pkg::CHAN_W-1:0] taps;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    taps[i * 3 + j] = win_reg[i][j][ch];
                end
            end
        end

        rbf_lane u_lane (
            .aclk (aclk),
            .en   (adv),
            .taps (taps),
            .mean (mean[ch])
        );
    end

    rbf_merge_out u_merge_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (v4_reg),
        .meta       (m4_reg),
        .mean       (mean),
        .mid_pix    (mid4_reg),
        .right_pix  (right4_reg),
        .take_ok    (adv),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

FILE: dv/rgb_box_filter_3x3_tb.sv
// rgb_box_filter_3x3_tb: self-checking testbench for the streaming rgb 3x3 mean filter
`timescale 1ns / 100ps
module rgb_box_filter_3x3_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int IDLE_PCT      = 14;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 10;
    localparam int EDGE_PIXELS   = 8;
    localparam int WIN           = 3;
    localparam logic [rbf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [rbf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [rbf_pkg::COORD_W-1:0] row;
        logic [rbf_pkg::COORD_W-1:0] col;
        rbf_pkg::pix_t               pix;
        logic                        run_end;
        logic                        frame_end;
    } out_pixel_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [rbf_pkg::CFG_W-1:0]      cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rbf_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [rbf_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    // filter state as seen from outside
    logic [rbf_pkg::CFG_W-1:0] width_setting;
    logic [rbf_pkg::CFG_W-1:0] height_setting;
    rbf_pkg::pix_t             upper_line [rbf_pkg::DEF_MAX_WIDTH];
    rbf_pkg::pix_t             lower_line [rbf_pkg::DEF_MAX_WIDTH];
    rbf_pkg::pix_t             window [rbf_pkg::TAPS];
    int unsigned               row_pos;
    int unsigned               col_pos;
    out_pixel_t                due_pixels [$];

    bit          idle_enable = 1'b1;
    int          hold_off = 0;
    int          fail_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_seen = 0;
    int unsigned cycle_count = 0;

    rgb_box_filter_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
        if (v < rbf_pkg::MIN_SIDE) return rbf_pkg::MIN_SIDE;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic out_pixel_t make_out(input int unsigned r, input int unsigned c,
                                            input rbf_pkg::pix_t p);
        out_pixel_t o;
        o.row       = rbf_pkg::COORD_W'(r);
        o.col       = rbf_pkg::COORD_W'(c);
        o.pix       = p;
        o.run_end   = 1'b0;
        o.frame_end = 1'b0;
        return o;
    endfunction

    function automatic rbf_pkg::pix_t window_mean();
        rbf_pkg::pix_t m;
        int unsigned   sum;
        for (int ch = 0; ch < rbf_pkg::NCHAN; ch++) begin
            sum = 0;
            for (int t = 0; t < rbf_pkg::TAPS; t++) sum += window[t][ch];
            m[ch] = rbf_pkg::CHAN_W'(sum / rbf_pkg::TAPS);
        end
        return m;
    endfunction

    function automatic void clear_filter_state();
        width_setting  = rbf_pkg::CFG_W'(rbf_pkg::RESET_WIDTH);
        height_setting = rbf_pkg::CFG_W'(rbf_pkg::RESET_HEIGHT);
        for (int i = 0; i < rbf_pkg::DEF_MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < rbf_pkg::TAPS; i++) window[i] = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    // expected results of one accepted pixel, appended in output order
    function automatic void filter_pixel(input rbf_pkg::pix_t p);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        out_pixel_t  batch [$];
        out_pixel_t  tail;
        w = clamp_side(width_setting, rbf_pkg::DEF_MAX_WIDTH);
        h = clamp_side(height_setting, rbf_pkg::MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        if (r >= h) r = 0;
        if (c >= w) c = 0;
        for (int i = 0; i < WIN; i++) begin
            window[i*WIN]   = window[i*WIN+1];
            window[i*WIN+1] = window[i*WIN+2];
        end
        window[WIN-1]           = upper_line[c];
        window[2*WIN-1]         = lower_line[c];
        window[rbf_pkg::TAPS-1] = p;
        if (r == 0) batch.push_back(make_out(0, c, p));
        if (r >= 2 && c >= 1)
            batch.push_back(make_out(r - 1, c - 1, (c >= 2) ? window_mean() : window[WIN+1]));
        if (r >= 2 && c == w - 1) batch.push_back(make_out(r - 1, c, window[2*WIN-1]));
        if (r == h - 1) batch.push_back(make_out(r, c, p));
        if (batch.size() > 0) begin
            tail = batch.pop_back();
            tail.run_end = 1'b1;
            tail.frame_end = (r == h - 1) && (c == w - 1);
            batch.push_back(tail);
        end
        foreach (batch[i]) due_pixels.push_back(batch[i]);
        upper_line[c] = lower_line[c];
        lower_line[c] = p;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic rbf_pkg::pix_t random_pixel();
        rbf_pkg::pix_t p;
        int unsigned   pick;
        pick = $urandom_range(0, 9);
        for (int ch = 0; ch < rbf_pkg::NCHAN; ch++) begin
            if (pick == 0) p[ch] = '0;
            else if (pick == 1) p[ch] = {rbf_pkg::CHAN_W{1'b1}};
            else p[ch] = rbf_pkg::CHAN_W'($urandom_range(0, 255));
        end
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_pixel(input rbf_pkg::pix_t p);
        while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p[rbf_pkg::CH_BLUE], p[rbf_pkg::CH_GREEN], p[rbf_pkg::CH_RED]};
        do @(posedge aclk); while (!s_tready);
        filter_pixel(p);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) send_pixel(random_pixel());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (due_pixels.size() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [rbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbf_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        unique case (idx)
            rbf_pkg::REG_IMAGE_WIDTH: begin
                width_setting = value;
                row_pos = 0;
                col_pos = 0;
            end
            rbf_pkg::REG_IMAGE_HEIGHT: begin
                height_setting = value;
                row_pos = 0;
                col_pos = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [rbf_pkg::CFG_W-1:0] w,
                             input logic [rbf_pkg::CFG_W-1:0] h);
        drain_results();
        write_reg(rbf_pkg::REG_IMAGE_WIDTH, w);
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    task automatic test_reset_defaults();
        send_pixel(24'h000000);
        send_pixel(24'hffffff);
        send_pixel(24'haaaaaa);
        send_pixel(24'h555555);
        send_pixel(24'hff0000);
        send_pixel(24'h0000ff);
    endtask

    task automatic test_smallest_frame();
        rbf_pkg::pix_t p;
        set_frame(3, 3);
        repeat (9) send_pixel(24'hffffff);
        for (int i = 0; i < 9; i++) begin
            p = (i % 2 == 0) ? 24'h000000 : 24'hffffff;
            p[rbf_pkg::CH_BLUE] = rbf_pkg::CHAN_W'(i * 31);
            send_pixel(p);
        end
    endtask

    task automatic test_wide_frame();
        set_frame(rbf_pkg::DEF_MAX_WIDTH, 0);
        send_random(EDGE_PIXELS);
    endtask

    task automatic test_tall_frame();
        set_frame(1, {rbf_pkg::CFG_W{1'b1}});
        send_random(rbf_pkg::MIN_SIDE * rbf_pkg::MIN_SIDE);
    endtask

    task automatic test_unused_index();
        set_frame(3, 3);
        send_random(4);
        drain_results();
        write_reg(REG_SPARE_LO, {rbf_pkg::CFG_W{1'b1}});
        write_reg(REG_SPARE_HI, '0);
        send_random(5);
    endtask

    task automatic test_mid_frame_restart();
        set_frame(5, 3);
        send_random(7);
        drain_results();
        write_reg(rbf_pkg::REG_IMAGE_HEIGHT, 4);
        send_random(20);
    endtask

    task automatic test_output_stall();
        set_frame(4, 3);
        hold_off = HOLD_CYCLES;
        send_random(12);
    endtask

    task automatic test_no_idle();
        drain_results();
        idle_enable = 1'b0;
        set_frame(6, 3);
        send_random(18);
        drain_results();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned cut;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            w = $urandom_range(3, 5);
            h = $urandom_range(3, 4);
            set_frame(rbf_pkg::CFG_W'(w), rbf_pkg::CFG_W'(h));
            n = w * h;
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n - 1);
            if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, n);
                send_random(cut);
                drain_results();
                send_random(n - cut);
            end else begin
                send_random(n);
            end
            sent += n;
        end
    endtask

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= !(idle_enable && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : check_output
        out_pixel_t want;
        out_pixel_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[rbf_pkg::COORD_W-1:0];
            got.col = m_tdata[2*rbf_pkg::COORD_W-1:rbf_pkg::COORD_W];
            got.pix[rbf_pkg::CH_RED]   = m_tdata[2*rbf_pkg::COORD_W +: rbf_pkg::CHAN_W];
            got.pix[rbf_pkg::CH_GREEN] =
                m_tdata[2*rbf_pkg::COORD_W+rbf_pkg::CHAN_W +: rbf_pkg::CHAN_W];
            got.pix[rbf_pkg::CH_BLUE]  =
                m_tdata[2*rbf_pkg::COORD_W+2*rbf_pkg::CHAN_W +: rbf_pkg::CHAN_W];
            got.run_end   = m_tlast;
            got.frame_end = m_tuser;
            if (due_pixels.size() == 0) begin
                fail_count++;
                $display("%0t unexpected transfer: row %0d col %0d rgb %h last %b frame %b",
                         $time, got.row, got.col, got.pix, got.run_end, got.frame_end);
            end else begin
                want = due_pixels.pop_front();
                results_checked++;
                if (got.frame_end) frames_seen++;
                if (got.row !== want.row || got.col !== want.col || got.pix !== want.pix ||
                    got.run_end !== want.run_end || got.frame_end !== want.frame_end) begin
                    fail_count++;
                    $display("%0t mismatch: expected row %0d col %0d rgb %h last %b frame %b, %s",
                             $time, want.row, want.col, want.pix, want.run_end,
                             want.frame_end,
                             $sformatf("got row %0d col %0d rgb %h last %b frame %b",
                                       got.row, got.col, got.pix, got.run_end,
                                       got.frame_end));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, due_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        clear_filter_state();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_smallest_frame();
        test_unused_index();
        test_mid_frame_restart();
        test_output_stall();
        test_no_idle();
        test_wide_frame();
        test_tall_frame();
        test_random_frames();
        drain_results();

        $display("sent %0d pixels, checked %0d results across %0d completed frames",
                 pixels_sent, results_checked, frames_seen);
        $display("small and clamped frame sizes, restarts, output stalls and idle gaps");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
